@@ rtl/ackw_pkg.sv @@
// shared types, constants and helpers of the keyword counter
// depends on nothing; imported by aho_corasick_keyword_counter_unit and ackw_ctrl
`timescale 1ns / 1ps

package ackw_pkg;

  // dictionary geometry
  localparam int MAX_NODES   = 8192;
  localparam int ALPHABET    = 26;
  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int SYM_W       = 5;
  localparam int CHILD_DEPTH = MAX_NODES * ALPHABET;
  localparam int CHILD_AW    = $clog2(CHILD_DEPTH);
  localparam int QPTR_W      = NODE_W + 1;

  // counters
  localparam int KW_W      = 13;
  localparam int TOTAL_W   = 14;
  localparam int KW_MAX    = 8191;
  localparam int TOTAL_MAX = 16383;

  // item kinds
  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_PATTERN = 2'd1,
    ACT_FINISH  = 2'd2,
    ACT_TEXT    = 2'd3
  } action_e;

  // child table port
  typedef struct packed {
    logic                we;
    logic [CHILD_AW-1:0] addr;
    logic [NODE_W-1:0]   wdata;
  } child_req_t;

  // per-node table port
  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] addr;
    logic [NODE_W-1:0] wdata;
  } node_req_t;

  // one result beat
  typedef struct packed {
    logic               done;
    logic               full;
    logic [TOTAL_W-1:0] total;
  } result_t;

  // row-major address of a child entry
  function automatic logic [CHILD_AW-1:0] child_addr(logic [NODE_W-1:0] n,
                                                     logic [SYM_W-1:0]  s);
    logic [CHILD_AW-1:0] base;
    base = CHILD_AW'(n) * CHILD_AW'(ALPHABET);
    return base + CHILD_AW'(s);
  endfunction

endpackage

@@ rtl/aho_corasick_keyword_counter_unit.sv @@
// Aho-Corasick keyword counter: one sequencer working over five table rams.
// An item is handled alone, from acceptance to its result; after reset the root
// row is cleared. The table rams have registered reads. A clear store resets the
// trie and clears the root row; a pattern letter clears the child row of any node
// it allocates; a text letter follows failure links and then the output chain,
// and a letter out of range is skipped; finish dictionary walks the trie breadth
// first to build the failure and output links. The result sits in an output
// register, so the next item is taken while it waits.
// depends on ackw_pkg, ackw_ram, ackw_ctrl
`timescale 1ns / 1ps

module aho_corasick_keyword_counter_unit import ackw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // action[1:0], symbol[6:2], zero[7]
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,  // match_total[13:0], trie_full[14], zero[15]
  output logic        m_axis_tlast_o
);

  child_req_t        child_req;
  node_req_t         fail_req, dict_req, kw_req, queue_req;
  logic [NODE_W-1:0] child_rd, fail_rd, dict_rd, queue_rd;
  logic [KW_W-1:0]   kw_rd;
  logic              res_valid, out_free;
  result_t           res;
  logic              out_valid_q;
  result_t           out_q;

  ackw_ram #(.WIDTH(NODE_W), .DEPTH(CHILD_DEPTH)) u_child (
    .clk_i, .we_i(child_req.we), .addr_i(child_req.addr),
    .wdata_i(child_req.wdata), .rdata_o(child_rd)
  );
  ackw_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_fail (
    .clk_i, .we_i(fail_req.we), .addr_i(fail_req.addr),
    .wdata_i(fail_req.wdata), .rdata_o(fail_rd)
  );
  ackw_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_dict (
    .clk_i, .we_i(dict_req.we), .addr_i(dict_req.addr),
    .wdata_i(dict_req.wdata), .rdata_o(dict_rd)
  );
  ackw_ram #(.WIDTH(KW_W), .DEPTH(MAX_NODES)) u_kw (
    .clk_i, .we_i(kw_req.we), .addr_i(kw_req.addr),
    .wdata_i(KW_W'(kw_req.wdata)), .rdata_o(kw_rd)
  );
  ackw_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (
    .clk_i, .we_i(queue_req.we), .addr_i(queue_req.addr),
    .wdata_i(queue_req.wdata), .rdata_o(queue_rd)
  );

  ackw_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .in_action_i   (action_e'(s_axis_tdata_i[1:0])),
    .in_symbol_i   (s_axis_tdata_i[6:2]),
    .in_last_i     (s_axis_tlast_i),
    .out_free_i    (out_free),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .child_req_o   (child_req),
    .child_rdata_i (child_rd),
    .fail_req_o    (fail_req),
    .fail_rdata_i  (fail_rd),
    .dict_req_o    (dict_req),
    .dict_rdata_i  (dict_rd),
    .kw_req_o      (kw_req),
    .kw_rdata_i    (kw_rd),
    .queue_req_o   (queue_req),
    .queue_rdata_i (queue_rd)
  );

  assign out_free = !out_valid_q || m_axis_tready_i;

  // output register holding one result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q.full, out_q.total};
  assign m_axis_tlast_o  = out_q.done;

endmodule

@@ rtl/ackw_ram.sv @@
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ackw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

@@ rtl/ackw_ctrl.sv @@
// sequencer that drives the trie, link, count and queue tables
// depends on ackw_pkg
`timescale 1ns / 1ps

module ackw_ctrl import ackw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  action_e           in_action_i,
  input  logic [SYM_W-1:0]  in_symbol_i,
  input  logic              in_last_i,
  input  logic              out_free_i,
  output logic              res_valid_o,
  output result_t           res_o,
  output child_req_t        child_req_o,
  input  logic [NODE_W-1:0] child_rdata_i,
  output node_req_t         fail_req_o,
  input  logic [NODE_W-1:0] fail_rdata_i,
  output node_req_t         dict_req_o,
  input  logic [NODE_W-1:0] dict_rdata_i,
  output node_req_t         kw_req_o,
  input  logic [KW_W-1:0]   kw_rdata_i,
  output node_req_t         queue_req_o,
  input  logic [NODE_W-1:0] queue_rdata_i
);

  typedef enum logic [4:0] {
    S_IDLE, S_ZROOT, S_CLR, S_P0, S_P1, S_PL, S_PK,
    S_FRR, S_FRC, S_FPOP, S_FU, S_FUF, S_FCR, S_FCC, S_FTO, S_FTC, S_FTF,
    S_FFK, S_FFW, S_TTO, S_TTC, S_TTF, S_TCOL, S_TCW, S_EMIT
  } state_e;

  state_e             state_q;
  logic               boot_q;
  action_e            act_q;
  logic [SYM_W-1:0]   sym_q, s_q;
  logic               last_q, full_q, dropped_q;
  logic [NODE_W-1:0]  nodes_used_q, pattern_q, text_q;
  logic [NODE_W-1:0]  c_q, u_q, fu_q, to_q, f_q;
  logic [QPTR_W-1:0]  head_q, tail_q;
  logic [TOTAL_W-1:0] total_q;

  logic               room, q_room, last_sym, hit;
  logic [NODE_W-1:0]  new_node, f_sel;
  logic [TOTAL_W:0]   total_sum;

  assign room      = nodes_used_q < NODE_W'(MAX_NODES - 1);
  assign q_room    = tail_q < QPTR_W'(MAX_NODES);
  assign new_node  = nodes_used_q + NODE_W'(1);
  assign last_sym  = s_q == SYM_W'(ALPHABET - 1);
  assign hit       = (child_rdata_i != '0) || (to_q == '0);
  assign f_sel     = (child_rdata_i == c_q) ? '0 : child_rdata_i;
  assign total_sum = {1'b0, total_q} + (TOTAL_W + 1)'(kw_rdata_i);

  assign in_ready_o  = state_q == S_IDLE;
  assign res_valid_o = state_q == S_EMIT;
  assign res_o.total = total_q;
  assign res_o.full  = full_q;
  assign res_o.done  = (act_q == ACT_TEXT) && last_q;

  // table requests per step
  always_comb begin
    child_req_o = '0;
    fail_req_o  = '0;
    dict_req_o  = '0;
    kw_req_o    = '0;
    queue_req_o = '0;
    case (state_q)
      S_ZROOT: begin
        fail_req_o.we = 1'b1;
        dict_req_o.we = 1'b1;
        kw_req_o.we   = 1'b1;
      end
      S_CLR: begin
        child_req_o.we   = 1'b1;
        child_req_o.addr = child_addr(c_q, s_q);
      end
      S_P0: child_req_o.addr = child_addr(pattern_q, sym_q);
      S_P1: begin
        if (child_rdata_i == '0 && room) begin
          child_req_o.we    = 1'b1;
          child_req_o.addr  = child_addr(pattern_q, sym_q);
          child_req_o.wdata = new_node;
          fail_req_o.we     = 1'b1;
          fail_req_o.addr   = new_node;
          dict_req_o.we     = 1'b1;
          dict_req_o.addr   = new_node;
          kw_req_o.we       = 1'b1;
          kw_req_o.addr     = new_node;
        end
      end
      S_PL: kw_req_o.addr = pattern_q;
      S_PK: begin
        kw_req_o.addr  = pattern_q;
        kw_req_o.we    = kw_rdata_i < KW_W'(KW_MAX);
        kw_req_o.wdata = kw_rdata_i + KW_W'(1);
      end
      S_FRR: child_req_o.addr = child_addr('0, s_q);
      S_FRC: begin
        if (child_rdata_i != '0 && q_room) begin
          fail_req_o.we     = 1'b1;
          fail_req_o.addr   = child_rdata_i;
          dict_req_o.we     = 1'b1;
          dict_req_o.addr   = child_rdata_i;
          queue_req_o.we    = 1'b1;
          queue_req_o.addr  = tail_q[NODE_W-1:0];
          queue_req_o.wdata = child_rdata_i;
        end
      end
      S_FPOP: queue_req_o.addr = head_q[NODE_W-1:0];
      S_FU:   fail_req_o.addr  = queue_rdata_i;
      S_FCR:  child_req_o.addr = child_addr(u_q, s_q);
      S_FCC: begin
        if (child_rdata_i != '0 && q_room) begin
          queue_req_o.we    = 1'b1;
          queue_req_o.addr  = tail_q[NODE_W-1:0];
          queue_req_o.wdata = child_rdata_i;
        end
      end
      S_FTO: child_req_o.addr = child_addr(to_q, s_q);
      S_FTC: fail_req_o.addr  = to_q;
      S_FFK: begin
        kw_req_o.addr   = f_q;
        dict_req_o.addr = f_q;
      end
      S_FFW: begin
        fail_req_o.we    = 1'b1;
        fail_req_o.addr  = c_q;
        fail_req_o.wdata = f_q;
        dict_req_o.we    = 1'b1;
        dict_req_o.addr  = c_q;
        dict_req_o.wdata = (kw_rdata_i != '0) ? f_q : dict_rdata_i;
      end
      S_TTO: child_req_o.addr = child_addr(to_q, sym_q);
      S_TTC: fail_req_o.addr  = to_q;
      S_TCOL: begin
        kw_req_o.addr   = f_q;
        dict_req_o.addr = f_q;
      end
      S_TCW: begin
        kw_req_o.we   = 1'b1;
        kw_req_o.addr = f_q;
      end
      default: ;
    endcase
  end

  // sequencer and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_ZROOT;
      boot_q       <= 1'b1;
      act_q        <= ACT_CLEAR;
      nodes_used_q <= '0;
      pattern_q    <= '0;
      text_q       <= '0;
      total_q      <= '0;
      c_q          <= '0;
      s_q          <= '0;
      full_q       <= 1'b0;
      dropped_q    <= 1'b0;
      last_q       <= 1'b0;
      head_q       <= '0;
      tail_q       <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            act_q     <= in_action_i;
            sym_q     <= in_symbol_i;
            last_q    <= in_last_i;
            full_q    <= 1'b0;
            dropped_q <= 1'b0;
            s_q       <= '0;
            to_q      <= text_q;
            case (in_action_i)
              ACT_CLEAR: begin
                nodes_used_q <= '0;
                pattern_q    <= '0;
                text_q       <= '0;
                total_q      <= '0;
                c_q          <= '0;
                state_q      <= S_ZROOT;
              end
              ACT_PATTERN: state_q <= (in_symbol_i < SYM_W'(ALPHABET)) ? S_P0 : S_PL;
              ACT_FINISH: begin
                text_q  <= '0;
                total_q <= '0;
                head_q  <= '0;
                tail_q  <= '0;
                state_q <= S_FRR;
              end
              default: state_q <= (in_symbol_i < SYM_W'(ALPHABET)) ? S_TTO : S_EMIT;
            endcase
          end
        end
        S_ZROOT: state_q <= S_CLR;
        // zero one child row
        S_CLR: begin
          s_q <= s_q + SYM_W'(1);
          if (last_sym) begin
            if (boot_q) begin
              boot_q  <= 1'b0;
              state_q <= S_IDLE;
            end else begin
              state_q <= (act_q == ACT_CLEAR) ? S_EMIT : S_PL;
            end
          end
        end
        // pattern letter
        S_P0: state_q <= S_P1;
        S_P1: begin
          if (child_rdata_i != '0) begin
            pattern_q <= child_rdata_i;
            state_q   <= S_PL;
          end else if (room) begin
            nodes_used_q <= new_node;
            pattern_q    <= new_node;
            c_q          <= new_node;
            s_q          <= '0;
            state_q      <= S_CLR;
          end else begin
            full_q    <= 1'b1;
            dropped_q <= 1'b1;
            state_q   <= S_PL;
          end
        end
        S_PL: begin
          if (!last_q) begin
            state_q <= S_EMIT;
          end else if (dropped_q) begin
            pattern_q <= '0;
            state_q   <= S_EMIT;
          end else begin
            state_q <= S_PK;
          end
        end
        S_PK: begin
          pattern_q <= '0;
          state_q   <= S_EMIT;
        end
        // finish: root children
        S_FRR: state_q <= S_FRC;
        S_FRC: begin
          if (child_rdata_i != '0 && q_room) begin
            tail_q <= tail_q + QPTR_W'(1);
          end
          s_q     <= s_q + SYM_W'(1);
          state_q <= last_sym ? S_FPOP : S_FRR;
        end
        // finish: breadth-first walk
        S_FPOP: begin
          if (head_q < tail_q) begin
            head_q  <= head_q + QPTR_W'(1);
            state_q <= S_FU;
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_FU: begin
          u_q     <= queue_rdata_i;
          state_q <= S_FUF;
        end
        S_FUF: begin
          fu_q    <= fail_rdata_i;
          s_q     <= '0;
          state_q <= S_FCR;
        end
        S_FCR: state_q <= S_FCC;
        S_FCC: begin
          if (child_rdata_i == '0) begin
            s_q     <= s_q + SYM_W'(1);
            state_q <= last_sym ? S_FPOP : S_FCR;
          end else begin
            if (q_room) begin
              tail_q <= tail_q + QPTR_W'(1);
            end
            c_q     <= child_rdata_i;
            to_q    <= fu_q;
            state_q <= S_FTO;
          end
        end
        S_FTO: state_q <= S_FTC;
        S_FTC: begin
          if (hit) begin
            f_q     <= f_sel;
            state_q <= S_FFK;
          end else begin
            state_q <= S_FTF;
          end
        end
        S_FTF: begin
          to_q    <= fail_rdata_i;
          state_q <= S_FTO;
        end
        S_FFK: state_q <= S_FFW;
        S_FFW: begin
          s_q     <= s_q + SYM_W'(1);
          state_q <= last_sym ? S_FPOP : S_FCR;
        end
        // text letter: goto / failure chase
        S_TTO: state_q <= S_TTC;
        S_TTC: begin
          if (hit) begin
            text_q  <= child_rdata_i;
            f_q     <= child_rdata_i;
            state_q <= S_TCOL;
          end else begin
            state_q <= S_TTF;
          end
        end
        S_TTF: begin
          to_q    <= fail_rdata_i;
          state_q <= S_TTO;
        end
        // output chain collection
        S_TCOL: state_q <= S_TCW;
        S_TCW: begin
          total_q <= (total_sum > (TOTAL_W + 1)'(TOTAL_MAX)) ? TOTAL_W'(TOTAL_MAX)
                                                            : total_sum[TOTAL_W-1:0];
          f_q     <= dict_rdata_i;
          state_q <= (dict_rdata_i == '0) ? S_EMIT : S_TCOL;
        end
        // hand the result to the output register
        S_EMIT: begin
          if (out_free_i) begin
            if (act_q == ACT_TEXT && last_q) begin
              text_q  <= '0;
              total_q <= '0;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
